[src/setx_pkg.sv]
// ----------------------------------------------------------------------------
// setx_pkg
// Shared types and constants for the start/end marker deframer with a
// 16-bit additive checksum.
// ----------------------------------------------------------------------------
package setx_pkg;

    localparam int PAYLOAD_BYTES = 64;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int IDX_W         = 6;
    localparam int SUM_W         = 16;
    localparam int BYTE_W        = 8;
    localparam int CFG_ADDR_W    = 1;
    localparam int M_TDATA_W     = 32;

    localparam logic [CNT_W-1:0]  LAST_CNT        = CNT_W'(PAYLOAD_BYTES - 1);
    localparam logic [BYTE_W-1:0] START_RESET_VAL = 8'h02;
    localparam logic [BYTE_W-1:0] END_RESET_VAL   = 8'h03;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_START_MARKER = 1'b0,
        REG_END_MARKER   = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_DATA = 3'd1,
        PH_SUMH = 3'd2,
        PH_SUML = 3'd3,
        PH_END  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD_SUM  = 2'd2,
        KIND_NO_END   = 2'd3
    } t_kind;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  byte_index;
        logic [SUM_W-1:0]  computed_sum;
    } t_result;

endpackage

[src/stx_etx_sum16_deframer.sv]
// ----------------------------------------------------------------------------
// stx_etx_sum16_deframer
// Byte-stream deframer: start marker, fixed-length payload, 16-bit additive
// checksum (high byte first) and end marker, with a per-frame verdict.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle while s_axis_tready is high; its
// result, if any, goes into a two-entry output buffer. The frame state and
// the 16-bit sum are updated in the accepting cycle; s_axis_tready falls
// only when both buffer entries are full. Payload bytes come out with kind 0
// and their index; the end byte gives one verdict (1 good, 2 checksum
// mismatch, 3 end marker missing) with the payload sum. Start and end marker values
// must be written via the cfg port only while idle; the block does not enforce it.
module stx_etx_sum16_deframer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [setx_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [setx_pkg::BYTE_W-1:0]         i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] in_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] data_byte, [13:8] byte_index, [29:14] computed_sum, [31:30] zero
    output logic [setx_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic [1:0]                          m_axis_tuser   // [1:0] kind
);

    logic [setx_pkg::BYTE_W-1:0] r_start_marker;
    logic [setx_pkg::BYTE_W-1:0] r_end_marker;

    logic                        s_accept;
    logic                        pop;
    setx_pkg::t_result           res;

    logic                        r_out_valid;
    setx_pkg::t_result           r_out;
    logic                        r_skid_valid;
    setx_pkg::t_result           r_skid;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= setx_pkg::START_RESET_VAL;
            r_end_marker   <= setx_pkg::END_RESET_VAL;
        end else if (i_cfg_we) begin
            case (setx_pkg::t_cfg_reg'(i_cfg_addr))
                setx_pkg::REG_START_MARKER: r_start_marker <= i_cfg_wdata;
                setx_pkg::REG_END_MARKER:   r_end_marker   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign pop           = r_out_valid && m_axis_tready;

    setx_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (s_accept),
        .i_byte         (s_axis_tdata),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_result       (res)
    );

    // two-entry output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= res.valid;
                end
            end else if (res.valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res.valid) begin
                r_out <= res;
            end
        end else if (res.valid) begin
            r_skid <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {2'b00, r_out.computed_sum, r_out.byte_index, r_out.data_byte};

    // a full buffer never takes a new result
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_skid_valid && res.valid))
        else $error("result arrived while output buffer full");

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output entry");

    a_data_no_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == setx_pkg::KIND_DATA) |-> (r_out.computed_sum == '0))
        else $error("payload result carries a sum");

    a_verdict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind != setx_pkg::KIND_DATA)
            |-> (r_out.data_byte == '0 && r_out.byte_index == '0))
        else $error("verdict carries payload fields");

endmodule

[src/setx_parser.sv]
// ----------------------------------------------------------------------------
// setx_parser
// Frame state machine: hunts for the start marker, passes payload bytes on
// with their index, collects the checksum and gives the frame verdict.
// ----------------------------------------------------------------------------
module setx_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [setx_pkg::BYTE_W-1:0]   i_byte,
    input  logic [setx_pkg::BYTE_W-1:0]   i_start_marker,
    input  logic [setx_pkg::BYTE_W-1:0]   i_end_marker,
    output setx_pkg::t_result             o_result
);

    setx_pkg::t_phase                 r_phase, n_phase;
    logic [setx_pkg::CNT_W-1:0]       r_count, n_count;
    logic [setx_pkg::SUM_W-1:0]       r_sum, n_sum;
    logic [setx_pkg::SUM_W-1:0]       r_rx_sum, n_rx_sum;

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_sum    = r_sum;
        n_rx_sum = r_rx_sum;
        if (i_accept) begin
            case (r_phase)
                setx_pkg::PH_DATA: begin
                    n_sum   = r_sum + setx_pkg::SUM_W'(i_byte);
                    n_count = r_count + 1'b1;
                    if (r_count == setx_pkg::LAST_CNT) begin
                        n_phase = setx_pkg::PH_SUMH;
                    end
                end
                setx_pkg::PH_SUMH: begin
                    n_rx_sum = {i_byte, 8'h00};
                    n_phase  = setx_pkg::PH_SUML;
                end
                setx_pkg::PH_SUML: begin
                    n_rx_sum = {r_rx_sum[15:8], i_byte};
                    n_phase  = setx_pkg::PH_END;
                end
                setx_pkg::PH_END: begin
                    n_phase  = setx_pkg::PH_HUNT;
                    n_count  = '0;
                    n_sum    = '0;
                    n_rx_sum = '0;
                end
                default: begin
                    if (i_byte == i_start_marker) begin
                        n_phase  = setx_pkg::PH_DATA;
                        n_count  = '0;
                        n_sum    = '0;
                        n_rx_sum = '0;
                    end else begin
                        n_phase = setx_pkg::PH_HUNT;
                    end
                end
            endcase
        end
    end

    // result for the accepted byte
    always_comb begin
        o_result              = '0;
        o_result.kind         = setx_pkg::KIND_DATA;
        if (i_accept) begin
            case (r_phase)
                setx_pkg::PH_DATA: begin
                    o_result.valid      = 1'b1;
                    o_result.kind       = setx_pkg::KIND_DATA;
                    o_result.data_byte  = i_byte;
                    o_result.byte_index = setx_pkg::IDX_W'(r_count);
                end
                setx_pkg::PH_END: begin
                    o_result.valid        = 1'b1;
                    o_result.computed_sum = r_sum;
                    if (i_byte != i_end_marker) begin
                        o_result.kind = setx_pkg::KIND_NO_END;
                    end else if (r_rx_sum != r_sum) begin
                        o_result.kind = setx_pkg::KIND_BAD_SUM;
                    end else begin
                        o_result.kind = setx_pkg::KIND_GOOD;
                    end
                end
                default: begin
                    o_result.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= setx_pkg::PH_HUNT;
            r_count  <= '0;
            r_sum    <= '0;
            r_rx_sum <= '0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_rx_sum <= n_rx_sum;
        end
    end

endmodule

[tb/stx_etx_sum16_deframer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_sum16_deframer_tb
// Self-checking testbench for the start/end marker deframer with a 16-bit
// additive checksum. A short table of typed bytes opens the run. It is
// followed by frames with random content and every verdict, under several
// marker settings. A behavioral deframer predicts the result of each byte outside the table.
// Both stream sides idle at random, and the receiver holds off for long
// stretches to back the block up.
// ----------------------------------------------------------------------------
module stx_etx_sum16_deframer_tb;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 250;
    localparam int N_DIR         = 14;
    localparam int N_PHASES      = 4;
    localparam int FRAMES_PER_PH = 3;

    typedef enum {FR_GOOD, FR_BAD_SUM, FR_NO_END, FR_BOTH} t_frame_mode;
    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MARKERS} t_fill;
    typedef enum {RX_OPEN, RX_RANDOM, RX_TOGGLE} t_rx_mode;

    typedef struct {
        setx_pkg::t_kind                 kind;
        logic [setx_pkg::BYTE_W-1:0]     data;
        logic [setx_pkg::IDX_W-1:0]      idx;
        logic [setx_pkg::SUM_W-1:0]      sum;
    } t_deframe_out;

    typedef struct {
        logic [setx_pkg::BYTE_W-1:0]     b;
        bit                              typed;
        bit                              has_res;
        setx_pkg::t_kind                 kind;
        logic [setx_pkg::BYTE_W-1:0]     data;
        logic [setx_pkg::IDX_W-1:0]      idx;
        logic [setx_pkg::SUM_W-1:0]      sum;
    } t_link_byte;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_cfg_we      = 1'b0;
    logic [setx_pkg::CFG_ADDR_W-1:0]     i_cfg_addr    = '0;
    logic [setx_pkg::BYTE_W-1:0]         i_cfg_wdata   = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [7:0]                          s_axis_tdata  = '0;   // [7:0] in_byte
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // [7:0] data_byte, [13:8] byte_index, [29:14] computed_sum, [31:30] zero
    logic [setx_pkg::M_TDATA_W-1:0]      m_axis_tdata;
    logic [1:0]                          m_axis_tuser;         // [1:0] kind

    // behavioral deframer state and marker copies
    setx_pkg::t_phase                    lnk_phase = setx_pkg::PH_HUNT;
    int                                  lnk_count = 0;
    logic [setx_pkg::SUM_W-1:0]          lnk_sum   = '0;
    logic [setx_pkg::SUM_W-1:0]          lnk_chk   = '0;
    logic [setx_pkg::BYTE_W-1:0]         start_mk  = setx_pkg::START_RESET_VAL;
    logic [setx_pkg::BYTE_W-1:0]         end_mk    = setx_pkg::END_RESET_VAL;

    t_link_byte             tx_bytes[$];
    t_deframe_out           pending_out[$];

    int err_cnt      = 0;
    int items_in     = 0;
    int results_seen = 0;
    int n_payload    = 0;
    int n_good       = 0;
    int n_bad_sum    = 0;
    int n_no_end     = 0;

    stx_etx_sum16_deframer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    task automatic deframe_predict(input logic [setx_pkg::BYTE_W-1:0] b, output bit got,
                                   output t_deframe_out r);
        r   = '{kind: setx_pkg::KIND_DATA, data: '0, idx: '0, sum: '0};
        got = 1'b0;
        case (lnk_phase)
            setx_pkg::PH_DATA: begin
                r.data    = b;
                r.idx     = lnk_count[setx_pkg::IDX_W-1:0];
                lnk_sum   = lnk_sum + setx_pkg::SUM_W'(b);
                lnk_count = lnk_count + 1;
                if (lnk_count >= setx_pkg::PAYLOAD_BYTES) begin
                    lnk_phase = setx_pkg::PH_SUMH;
                end
                got = 1'b1;
            end
            setx_pkg::PH_SUMH: begin
                lnk_chk   = {b, 8'h00};
                lnk_phase = setx_pkg::PH_SUML;
            end
            setx_pkg::PH_SUML: begin
                lnk_chk[7:0] = b;
                lnk_phase    = setx_pkg::PH_END;
            end
            setx_pkg::PH_END: begin
                // a wrong end byte wins over a checksum mismatch
                if (b != end_mk) begin
                    r.kind = setx_pkg::KIND_NO_END;
                end else if (lnk_chk != lnk_sum) begin
                    r.kind = setx_pkg::KIND_BAD_SUM;
                end else begin
                    r.kind = setx_pkg::KIND_GOOD;
                end
                r.sum     = lnk_sum;
                got       = 1'b1;
                lnk_phase = setx_pkg::PH_HUNT;
                lnk_count = 0;
                lnk_sum   = '0;
                lnk_chk   = '0;
            end
            default: begin
                if (b == start_mk) begin
                    lnk_phase = setx_pkg::PH_DATA;
                    lnk_count = 0;
                    lnk_sum   = '0;
                    lnk_chk   = '0;
                end else begin
                    lnk_phase = setx_pkg::PH_HUNT;
                end
            end
        endcase
    endtask

    task automatic push_byte(input logic [setx_pkg::BYTE_W-1:0] b);
        tx_bytes.push_back('{b: b, typed: 1'b0, has_res: 1'b0, kind: setx_pkg::KIND_DATA,
                             data: '0, idx: '0, sum: '0});
    endtask

    // payload from position first on, then checksum and end byte
    task automatic queue_frame(input int first, input logic [setx_pkg::SUM_W-1:0] sum_in,
                               input t_frame_mode mode, input t_fill fill);
        logic [setx_pkg::SUM_W-1:0]  s;
        logic [setx_pkg::BYTE_W-1:0] b;
        logic [setx_pkg::BYTE_W-1:0] eb;
        s = sum_in;
        for (int i = first; i < setx_pkg::PAYLOAD_BYTES; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                FILL_MARKERS: begin
                    case ($urandom_range(0, 2))
                        0:       b = start_mk;
                        1:       b = end_mk;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                end
                default: b = 8'($urandom_range(0, 255));
            endcase
            push_byte(b);
            s = s + setx_pkg::SUM_W'(b);
        end
        eb = end_mk;
        if (mode == FR_BAD_SUM || mode == FR_BOTH) begin
            s = s ^ 16'($urandom_range(1, 16'hFFFF));
        end
        if (mode == FR_NO_END || mode == FR_BOTH) begin
            eb = eb ^ 8'($urandom_range(1, 255));
        end
        push_byte(s[15:8]);
        push_byte(s[7:0]);
        push_byte(eb);
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (tx_bytes.size() != 0 || pending_out.size() != 0 || s_axis_tvalid);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_markers(input logic [setx_pkg::BYTE_W-1:0] s,
                                 input logic [setx_pkg::BYTE_W-1:0] e);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= setx_pkg::REG_START_MARKER;
        i_cfg_wdata <= s;
        @(posedge i_clk);
        start_mk     = s;
        i_cfg_addr  <= setx_pkg::REG_END_MARKER;
        i_cfg_wdata <= e;
        @(posedge i_clk);
        end_mk       = e;
        i_cfg_we    <= 1'b0;
    endtask

    // sender: bursts of random length with random gaps
    initial begin : tx_side
        t_link_byte   row;
        t_deframe_out want;
        bit           got;
        bit           busy;
        int           burst_left;
        int           gap_left;
        burst_left = 0;
        gap_left   = 0;
        forever begin
            @(posedge i_clk);
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                row      = tx_bytes.pop_front();
                items_in = items_in + 1;
                deframe_predict(row.b, got, want);
                if (row.typed) begin
                    got  = row.has_res;
                    want = '{kind: row.kind, data: row.data, idx: row.idx, sum: row.sum};
                end
                if (got) begin
                    pending_out.push_back(want);
                end
                busy       = 1'b0;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            if (!busy) begin
                if (gap_left > 0 || tx_bytes.size() == 0) begin
                    if (gap_left > 0) begin
                        gap_left = gap_left - 1;
                    end
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= tx_bytes[0].b;
                end
            end
        end
    end

    // receiver: stall modes that change after random runs, plus long holds
    initial begin : rx_side
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       next_hold;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        next_hold = 300;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (results_seen >= next_hold) begin
                hold_left = LONG_HOLD;
                next_hold = next_hold + 500;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left = mode_left - 1;
                case (mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_axis_tready <= ~m_axis_tready;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_deframe_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen = results_seen + 1;
            if (pending_out.size() == 0) begin
                err_cnt = err_cnt + 1;
                $display("%0t: unexpected transaction kind %0d tdata %h", $time,
                         m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_out.pop_front();
                case (want.kind)
                    setx_pkg::KIND_DATA:    n_payload = n_payload + 1;
                    setx_pkg::KIND_GOOD:    n_good    = n_good + 1;
                    setx_pkg::KIND_BAD_SUM: n_bad_sum = n_bad_sum + 1;
                    default:                n_no_end  = n_no_end + 1;
                endcase
                if (m_axis_tuser != want.kind || m_axis_tdata[7:0] != want.data
                        || m_axis_tdata[13:8] != want.idx
                        || m_axis_tdata[29:14] != want.sum
                        || m_axis_tdata[31:30] != 2'b00) begin
                    err_cnt = err_cnt + 1;
                    $display("%0t: mismatch exp kind %0d byte %h idx %0d sum %h",
                             $time, want.kind, want.data, want.idx, want.sum);
                    $display("%0t:          got kind %0d byte %h idx %0d sum %h pad %b",
                             $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8],
                             m_axis_tdata[29:14], m_axis_tdata[31:30]);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || i_cfg_we) begin
                quiet = 0;
            end else begin
                quiet = quiet + 1;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : run
        t_link_byte                  dir_rows[N_DIR];
        logic [setx_pkg::SUM_W-1:0]  dir_sum;
        logic [setx_pkg::BYTE_W-1:0] mk;
        t_frame_mode                 mode;
        t_fill                       fill;
        int                          r;
        dir_rows = '{
            // hunting: noise, end marker and finally the start marker, all silent
            '{8'h00, 1'b1, 1'b0, setx_pkg::KIND_DATA, 8'h00, 6'd0, 16'h0000},
            '{8'hFF, 1'b1, 1'b0, setx_pkg::KIND_DATA, 8'h00, 6'd0, 16'h0000},
            '{8'h03, 1'b1, 1'b0, setx_pkg::KIND_DATA, 8'h00, 6'd0, 16'h0000},
            '{8'h02, 1'b1, 1'b0, setx_pkg::KIND_DATA, 8'h00, 6'd0, 16'h0000},
            // payload extremes and marker values taken as data
            '{8'h00, 1'b1, 1'b1, setx_pkg::KIND_DATA, 8'h00, 6'd0, 16'h0000},
            '{8'hFF, 1'b1, 1'b1, setx_pkg::KIND_DATA, 8'hFF, 6'd1, 16'h0000},
            '{8'h02, 1'b1, 1'b1, setx_pkg::KIND_DATA, 8'h02, 6'd2, 16'h0000},
            '{8'h03, 1'b1, 1'b1, setx_pkg::KIND_DATA, 8'h03, 6'd3, 16'h0000},
            '{8'h80, 1'b1, 1'b1, setx_pkg::KIND_DATA, 8'h80, 6'd4, 16'h0000},
            '{8'h7F, 1'b1, 1'b1, setx_pkg::KIND_DATA, 8'h7F, 6'd5, 16'h0000},
            '{8'h01, 1'b1, 1'b1, setx_pkg::KIND_DATA, 8'h01, 6'd6, 16'h0000},
            '{8'hFE, 1'b1, 1'b1, setx_pkg::KIND_DATA, 8'hFE, 6'd7, 16'h0000},
            '{8'h55, 1'b1, 1'b1, setx_pkg::KIND_DATA, 8'h55, 6'd8, 16'h0000},
            '{8'hAA, 1'b1, 1'b1, setx_pkg::KIND_DATA, 8'hAA, 6'd9, 16'h0000}
        };
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_sum = '0;
        for (int i = 0; i < N_DIR; i++) begin
            tx_bytes.push_back(dir_rows[i]);
            if (dir_rows[i].has_res) begin
                dir_sum = dir_sum + setx_pkg::SUM_W'(dir_rows[i].data);
            end
        end
        queue_frame(10, dir_sum, FR_GOOD, FILL_RANDOM);
        // one frame per verdict plus one with both faults, with all-ones, all-zero, marker and random payloads
        push_byte(start_mk);
        queue_frame(0, '0, FR_GOOD, FILL_ONES);
        push_byte(start_mk);
        queue_frame(0, '0, FR_BAD_SUM, FILL_ZERO);
        push_byte(start_mk);
        queue_frame(0, '0, FR_NO_END, FILL_MARKERS);
        push_byte(start_mk);
        queue_frame(0, '0, FR_BOTH, FILL_RANDOM);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    1: write_markers(8'h00, 8'hFF);
                    2: write_markers(8'hFF, 8'h00);
                    default: begin
                        mk = 8'($urandom_range(0, 255));
                        write_markers(mk, mk);
                    end
                endcase
            end
            for (int f = 0; f < FRAMES_PER_PH; f++) begin
                r = $urandom_range(0, 3);
                for (int k = 0; k < r; k++) begin
                    do begin
                        mk = 8'($urandom_range(0, 255));
                    end while (mk == start_mk);
                    push_byte(mk);
                end
                push_byte(start_mk);
                if ($urandom_range(0, 9) == 0) begin
                    // cut short: whatever follows is swallowed into this frame
                    r = $urandom_range(1, 20);
                    for (int k = 0; k < r; k++) begin
                        push_byte(8'($urandom_range(0, 255)));
                    end
                end else begin
                    case ($urandom_range(0, 5))
                        3:       mode = FR_BAD_SUM;
                        4:       mode = FR_NO_END;
                        5:       mode = FR_BOTH;
                        default: mode = FR_GOOD;
                    endcase
                    case ($urandom_range(0, 7))
                        0:       fill = FILL_ZERO;
                        1:       fill = FILL_ONES;
                        2:       fill = FILL_MARKERS;
                        default: fill = FILL_RANDOM;
                    endcase
                    queue_frame(0, '0, mode, fill);
                end
            end
        end
        wait_drained();

        if (pending_out.size() != 0) begin
            err_cnt = err_cnt + 1;
            $display("%0t: %0d results never arrived", $time, pending_out.size());
        end
        $display("covered %0d bytes in, %0d payload bytes out, %0d marker settings",
                 items_in, n_payload, N_PHASES);
        $display("verdicts: %0d good, %0d checksum mismatch, %0d end marker missing",
                 n_good, n_bad_sum, n_no_end);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
